>>> rtl/core/obst_pkg.sv
// Shared constants and types for the optimal BST reconstruction block.
package obst_pkg;

  // Default largest number of keys in a tree.
  localparam int unsigned MaxKeysDefault = 16;

  // Fixed width of every key, range and index field on the channels.
  localparam int unsigned FieldW = 5;

  // One extra bit so that a key range bound and a table root compare safely.
  localparam int unsigned CmpW = FieldW + 1;

  // Configuration port widths.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register index taken from the word address bit of paddr.
  localparam logic RegNumKeys = 1'b0;

  // Position of a node relative to its parent.
  typedef enum logic [1:0] {
    RelRoot  = 2'd0,
    RelLeft  = 2'd1,
    RelRight = 2'd2
  } rel_e;

endpackage

>>> rtl/core/obst_if.sv
// Valid/ready channel interfaces for table entries and tree node records.
interface obst_in_if;
  logic                        valid;
  logic                        ready;
  logic [obst_pkg::FieldW-1:0] range_start;
  logic [obst_pkg::FieldW-1:0] range_end;
  logic [obst_pkg::FieldW-1:0] root_key;
  logic                        last_entry;

  modport source (output valid, range_start, range_end, root_key, last_entry,
                  input ready);
  modport sink (input valid, range_start, range_end, root_key, last_entry,
                output ready);
endinterface

interface obst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        node_kind;
  logic [obst_pkg::FieldW-1:0] node_index;
  logic [1:0]                  relation;
  logic [obst_pkg::FieldW-1:0] parent_key;
  logic                        walk_error;
  logic                        last_record;

  modport source (output valid, node_kind, node_index, relation, parent_key,
                  walk_error, last_record, input ready);
  modport sink (input valid, node_kind, node_index, relation, parent_key,
                walk_error, last_record, output ready);
endinterface

>>> rtl/core/optimal_bst_tree_from_root_table.sv
// Optimal BST reconstruction: stores a root table and walks it in preorder.
//
// Usage: table entries (range_start, range_end, root_key) arrive on in_i and
// are written into the root table memory, one entry per cycle while the block
// is idle. An entry with a bad address (zero, above MAX_KEYS, or end before
// start) is not stored. An entry flagged last_entry is stored if its address is
// sound and then starts a preorder walk over keys 1..num_keys. The walk sends
// one item per tree node on out_o: 2*num_keys+1 items, the final one flagged
// last_record. A table root outside its range ends the walk with one error item.
// The num_keys register is to be written over the APB port only while the block
// is idle, which the block itself does not enforce; writes are clamped to 1..MAX_KEYS.
// Timing: in_i.ready is high only between walks. After the last entry is
// taken, the walk reads the root table in StEval and registers the first
// record in StRoot. A key node takes a table read (StEval), then a check and
// emit (StRoot); a dummy leaf is emitted from StEval, then StPop loads the next
// pending right subtree read from the stack memory. Both memories have
// registered reads.
// Reset: the walk stops, the stack pointer clears and num_keys returns to 1;
// the table memory keeps no reset value. When the receiver stalls, the
// pending record holds in the output register and the walk waits on it.
module optimal_bst_tree_from_root_table #(
  parameter int unsigned MAX_KEYS = obst_pkg::MaxKeysDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  obst_in_if.sink                     in_i,
  obst_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [obst_pkg::PaddrW-1:0] paddr,
  input  logic [obst_pkg::PdataW-1:0] pwdata,
  output logic [obst_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import obst_pkg::*;

  // Range bounds run from 0 up to MAX_KEYS+1.
  localparam int unsigned KW = $clog2(MAX_KEYS + 2);
  // Key count and stack pointer run from 0 up to MAX_KEYS.
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);
  // Index of one key bound into the table, and of one stack entry.
  localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned RootDepth = 2 ** (2 * IW);

  typedef struct packed {
    logic [KW-1:0] lo;
    logic [KW-1:0] hi;
    logic [KW-1:0] par;
    rel_e          mode;
  } frame_t;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StRoot,
    StPop
  } st_e;

  st_e               state_q;
  logic [NW-1:0]     num_keys_q;
  logic [NW-1:0]     sp_q;
  frame_t            cur_q;

  logic              out_valid_q;
  logic              out_kind_q;
  logic [FieldW-1:0] out_index_q;
  rel_e              out_rel_q;
  logic [FieldW-1:0] out_par_q;
  logic              out_err_q;
  logic              out_last_q;

  logic [FieldW-1:0] root_mem [RootDepth];
  logic [FieldW-1:0] root_rd_q;
  frame_t            stack_mem [MAX_KEYS];
  frame_t            stack_rd_q;

  logic              cfg_wr;
  logic [FieldW-1:0] cfg_val;
  logic [FieldW-1:0] cfg_clamped;
  logic              in_acc;
  logic              entry_ok;
  logic [2*IW-1:0]   waddr;
  logic [2*IW-1:0]   raddr;
  logic              slot_free;
  logic              is_dummy;
  logic              rd_root_en;
  logic              pop_en;
  logic              push_en;
  logic              rec_emit;
  logic [CmpW-1:0]   root_cmp;
  logic              in_range;
  logic [KW-1:0]     root_k;
  logic [KW-1:0]     dummy_par;
  logic [NW-1:0]     sp_m1;

  // Configuration port: writes complete in the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_val = pwdata[FieldW-1:0];
  assign prdata  = (paddr[PaddrW-1] == RegNumKeys) ? PdataW'(num_keys_q) : '0;

  always_comb begin
    if (cfg_val == '0) begin
      cfg_clamped = FieldW'(1);
    end else if (cfg_val > FieldW'(MAX_KEYS)) begin
      cfg_clamped = FieldW'(MAX_KEYS);
    end else begin
      cfg_clamped = cfg_val;
    end
  end

  // Input side: entries are taken only between walks.
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid & in_i.ready;
  assign entry_ok   = (in_i.range_start != '0) && (in_i.range_end != '0) &&
                      (in_i.range_start <= FieldW'(MAX_KEYS)) &&
                      (in_i.range_end <= FieldW'(MAX_KEYS)) &&
                      (in_i.range_end >= in_i.range_start);
  assign waddr      = {IW'(in_i.range_start - FieldW'(1)),
                       IW'(in_i.range_end - FieldW'(1))};
  assign raddr      = {IW'(cur_q.lo - KW'(1)), IW'(cur_q.hi - KW'(1))};

  // Walk control decodes.
  assign slot_free  = ~out_valid_q | out_o.ready;
  assign is_dummy   = (cur_q.lo > cur_q.hi);
  assign rd_root_en = (state_q == StEval) && !is_dummy;
  assign pop_en     = (state_q == StEval) && is_dummy && slot_free && (sp_q != '0);
  assign root_cmp   = CmpW'(root_rd_q);
  assign in_range   = (root_cmp >= CmpW'(cur_q.lo)) && (root_cmp <= CmpW'(cur_q.hi));
  assign push_en    = (state_q == StRoot) && slot_free && in_range;
  assign rec_emit   = slot_free && (((state_q == StEval) && is_dummy) ||
                                    (state_q == StRoot));
  assign root_k     = KW'(root_rd_q);
  assign sp_m1      = sp_q - NW'(1);
  assign dummy_par  = (cur_q.mode == RelLeft) ? KW'(cur_q.hi + KW'(1))
                                              : KW'(cur_q.lo - KW'(1));

  // Root table memory: written by entries, read by the walk.
  always_ff @(posedge clk_i) begin
    if (in_acc && entry_ok) begin
      root_mem[waddr] <= in_i.root_key;
    end
    if (rd_root_en) begin
      root_rd_q <= root_mem[raddr];
    end
  end

  // Stack memory of pending right subtrees.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[sp_q[IW-1:0]] <= '{lo: KW'(root_k + KW'(1)), hi: cur_q.hi,
                                   par: root_k, mode: RelRight};
    end
    if (pop_en) begin
      stack_rd_q <= stack_mem[sp_m1[IW-1:0]];
    end
  end

  // Walk state machine and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      num_keys_q  <= NW'(1);
      sp_q        <= '0;
      cur_q       <= '{lo: '0, hi: '0, par: '0, mode: RelRoot};
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_index_q <= '0;
      out_rel_q   <= RelRoot;
      out_par_q   <= '0;
      out_err_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[PaddrW-1] == RegNumKeys)) begin
        num_keys_q <= NW'(cfg_clamped);
      end
      // A new record takes the output register; otherwise a taken one leaves it.
      if (rec_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc && in_i.last_entry) begin
            cur_q   <= '{lo: KW'(1), hi: KW'(num_keys_q), par: '0, mode: RelRoot};
            sp_q    <= '0;
            state_q <= StEval;
          end
        end
        StEval: begin
          if (!is_dummy) begin
            state_q <= StRoot;
          end else if (slot_free) begin
            // Dummy leaf d_hi; the walk ends when no subtree is pending.
            out_kind_q  <= 1'b1;
            out_index_q <= FieldW'(cur_q.hi);
            out_rel_q   <= cur_q.mode;
            out_par_q   <= FieldW'(dummy_par);
            out_err_q   <= 1'b0;
            out_last_q  <= (sp_q == '0);
            if (sp_q == '0) begin
              state_q <= StIdle;
            end else begin
              sp_q    <= sp_m1;
              state_q <= StPop;
            end
          end
        end
        StRoot: begin
          if (slot_free) begin
            out_kind_q  <= 1'b0;
            out_index_q <= root_rd_q;
            out_rel_q   <= cur_q.mode;
            out_par_q   <= FieldW'(cur_q.par);
            if (!in_range) begin
              // Root outside its range: report and stop the walk.
              out_err_q  <= 1'b1;
              out_last_q <= 1'b1;
              sp_q       <= '0;
              state_q    <= StIdle;
            end else begin
              // Key node: descend left now, keep the right subtree on the stack.
              out_err_q  <= 1'b0;
              out_last_q <= 1'b0;
              sp_q       <= sp_q + NW'(1);
              cur_q      <= '{lo: cur_q.lo, hi: KW'(root_k - KW'(1)), par: root_k,
                              mode: RelLeft};
              state_q    <= StEval;
            end
          end
        end
        StPop: begin
          cur_q   <= stack_rd_q;
          state_q <= StEval;
        end
      endcase
    end
  end

  // Output channel.
  assign out_o.valid       = out_valid_q;
  assign out_o.node_kind   = out_kind_q;
  assign out_o.node_index  = out_index_q;
  assign out_o.relation    = out_rel_q;
  assign out_o.parent_key  = out_par_q;
  assign out_o.walk_error  = out_err_q;
  assign out_o.last_record = out_last_q;

endmodule

>>> rtl/core/obst_checker.sv
// Port-level assertions for the optimal BST reconstruction block, with bind.
module obst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_kind_i,
  input logic [obst_pkg::FieldW-1:0] out_index_i,
  input logic [1:0]                  out_rel_i,
  input logic [obst_pkg::FieldW-1:0] out_par_i,
  input logic                        out_err_i,
  input logic                        out_last_i
);
  import obst_pkg::*;

  // A stalled record stays offered with the same kind, index, relation, parent and last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) &&
    $stable(out_par_i) && $stable(out_rel_i) && $stable(out_kind_i) &&
    $stable(out_last_i))
    else $error("stalled record changed");

  // The final entry starts a walk, so no further entry is taken right after.
  a_walk_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("entry accepted while walk starts");

  // An ordinary entry only fills the table and the block stays ready.
  a_load_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("ready dropped after a table entry");

  // An error record always ends the walk.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_last_i)
    else $error("error record not flagged last");

  // The root record is a key node without a parent.
  a_root_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_rel_i == RelRoot) |-> (out_par_i == '0) && !out_kind_i)
    else $error("root record with parent or dummy kind");

endmodule

bind optimal_bst_tree_from_root_table obst_checker u_obst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_entry),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.node_kind),
  .out_index_i (out_o.node_index),
  .out_rel_i   (out_o.relation),
  .out_par_i   (out_o.parent_key),
  .out_err_i   (out_o.walk_error),
  .out_last_i  (out_o.last_record)
);

>>> verif/obst_walk_checker.sv
// Checker for the BST walk: mirrors the root table, predicts node records, compares them.
module obst_walk_checker
  import obst_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MaxKeysDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  obst_in_if                in_i,
  obst_out_if               out_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output int                mismatches_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = MAX_KEYS + 1;
  localparam int          MaxReports = 10;
  localparam logic        KindKey    = 1'b0;
  localparam logic        KindDummy  = 1'b1;

  typedef struct packed {
    logic              node_kind;
    logic [FieldW-1:0] node_index;
    rel_e              relation;
    logic [FieldW-1:0] parent_key;
    logic              walk_error;
    logic              last_record;
  } node_rec_t;

  // One pending key range of the walk.
  typedef struct {
    int   lo;
    int   hi;
    int   parent;
    rel_e mode;
  } span_t;

  logic [FieldW-1:0] root_table [MAX_KEYS][MAX_KEYS];
  node_rec_t         records_q [$];
  span_t             span_stack [StackDepth];
  int                key_count;
  int                fail_count = 0;

  assign mismatches_o = fail_count;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int        lo;
    int        hi;
    int        root;
    int        depth;
    int        cfg;
    bit        halted;
    span_t     s;
    node_rec_t rec;
    node_rec_t got;
    node_rec_t want;
    if (!rst_ni) begin
      key_count = 1;
      records_q.delete();
      pending_o <= 0;
    end else begin
      // Register write at the access phase; the low five bits are clamped to 1..MAX_KEYS.
      if (psel && penable && pwrite && pready && paddr[2] == RegNumKeys) begin
        cfg = int'(pwdata[FieldW-1:0]);
        if (cfg < 1) cfg = 1;
        if (cfg > MAX_KEYS) cfg = MAX_KEYS;
        key_count = cfg;
      end

      // Table entry: store it when the address is sound, then walk if it is the last one.
      if (in_i.valid && in_i.ready) begin
        lo = int'(in_i.range_start);
        hi = int'(in_i.range_end);
        if (lo >= 1 && hi >= 1 && lo <= MAX_KEYS && hi <= MAX_KEYS && hi >= lo)
          root_table[lo-1][hi-1] = in_i.root_key;
        if (in_i.last_entry) begin
          span_stack[0] = '{lo: 1, hi: key_count, parent: 0, mode: RelRoot};
          depth = 1;
          halted = 1'b0;
          while (depth > 0 && !halted) begin
            depth--;
            s = span_stack[depth];
            rec.relation    = s.mode;
            rec.walk_error  = 1'b0;
            rec.last_record = 1'b0;
            if (s.lo > s.hi) begin
              // Empty range: dummy leaf, hung under the key beside it.
              rec.node_kind  = KindDummy;
              rec.node_index = FieldW'(s.hi);
              rec.parent_key = FieldW'((s.mode == RelLeft) ? s.hi + 1 : s.lo - 1);
            end else begin
              root = 0;
              if (s.lo >= 1 && s.hi <= MAX_KEYS) root = int'(root_table[s.lo-1][s.hi-1]);
              rec.node_kind  = KindKey;
              rec.node_index = FieldW'(root);
              rec.parent_key = FieldW'(s.parent);
              if (root < s.lo || root > s.hi) begin
                rec.walk_error = 1'b1;
                halted = 1'b1;
              end else begin
                // Right range goes below the left so the left subtree is visited first.
                if (depth < StackDepth) begin
                  span_stack[depth] = '{lo: root + 1, hi: s.hi, parent: root, mode: RelRight};
                  depth++;
                end
                if (depth < StackDepth) begin
                  span_stack[depth] = '{lo: s.lo, hi: root - 1, parent: root, mode: RelLeft};
                  depth++;
                end
              end
            end
            records_q = {records_q, rec};
          end
          rec = records_q[$];
          rec.last_record = 1'b1;
          records_q[$] = rec;
        end
      end

      // Node record leaving the block: compare with the oldest prediction.
      if (out_i.valid && out_i.ready) begin
        got.node_kind   = out_i.node_kind;
        got.node_index  = out_i.node_index;
        got.relation    = rel_e'(out_i.relation);
        got.parent_key  = out_i.parent_key;
        got.walk_error  = out_i.walk_error;
        got.last_record = out_i.last_record;
        if (records_q.size() == 0) begin
          if (fail_count < MaxReports)
            $display("%0t: unexpected node record kind %0d index %0d rel %0d parent %0d err %0d last %0d",
                     $realtime, got.node_kind, got.node_index, got.relation, got.parent_key,
                     got.walk_error, got.last_record);
          fail_count++;
        end else begin
          want = records_q.pop_front();
          if (got.node_kind !== want.node_kind || got.node_index !== want.node_index ||
              got.relation !== want.relation || got.parent_key !== want.parent_key ||
              got.walk_error !== want.walk_error || got.last_record !== want.last_record) begin
            if (fail_count < MaxReports) begin
              $display("%0t: node record mismatch", $realtime);
              $display("  expected kind %0d index %0d rel %0d parent %0d err %0d last %0d",
                       want.node_kind, want.node_index, want.relation, want.parent_key,
                       want.walk_error, want.last_record);
              $display("  actual   kind %0d index %0d rel %0d parent %0d err %0d last %0d",
                       got.node_kind, got.node_index, got.relation, got.parent_key,
                       got.walk_error, got.last_record);
            end
            fail_count++;
          end
        end
      end

      pending_o <= records_q.size();
    end
  end

endmodule

>>> verif/optimal_bst_tree_from_root_table_tb.sv
// Testbench top: clock, reset, table entry stimulus, register writes and the verdict.
module optimal_bst_tree_from_root_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obst_pkg::*;

  localparam int MaxKeys      = MaxKeysDefault;
  localparam int RandomItems  = 200;
  localparam int DrainCycles  = 16;
  localparam int CycleLimit   = 400_000;

  typedef struct {
    int   lo;
    int   hi;
    int   root;
    logic start_walk;
  } entry_t;

  typedef enum int {ShapeMixed, ShapeLeftChain, ShapeRightChain} shape_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                pending;
  int                cycle_count;
  int                stored_items;
  bit                tx_calm;
  bit                rx_calm;
  bit                table_ok;
  entry_t            plan_q [$];

  obst_in_if  in_if ();
  obst_out_if out_if ();

  optimal_bst_tree_from_root_table #(
    .MAX_KEYS(MaxKeys)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  obst_walk_checker #(
    .MAX_KEYS(MaxKeys)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_i       (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit: a hung walk ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Record receiver: a random stall before each item, with calm stretches.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Send one table entry after a random gap and wait until it is taken.
  task automatic send_entry(input int lo, input int hi, input int root, input logic start_walk);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.range_start <= FieldW'(lo);
    in_if.range_end   <= FieldW'(hi);
    in_if.root_key    <= FieldW'(root);
    in_if.last_entry  <= start_walk;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // An entry whose address is unusable; the block drops it but honors its walk flag.
  task automatic send_dropped(input logic start_walk);
    int lo;
    int hi;
    case ($urandom_range(0, 3))
      0: begin
        lo = 0;
        hi = $urandom_range(0, 31);
      end
      1: begin
        lo = $urandom_range(MaxKeys + 1, 31);
        hi = $urandom_range(0, 31);
      end
      2: begin
        lo = $urandom_range(1, MaxKeys);
        hi = $urandom_range(MaxKeys + 1, 31);
      end
      default: begin
        lo = $urandom_range(2, MaxKeys);
        hi = $urandom_range(0, lo - 1);
      end
    endcase
    send_entry(lo, hi, $urandom_range(0, 31), start_walk);
  endtask

  // Hold off until every predicted record has come and the block has gone quiet.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of num_keys, only with the block idle.
  task automatic write_key_count(input logic [PdataW-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegNumKeys, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Build a random tree over keys 1..n as shuffled entries; optionally break one root.
  task automatic plan_tree(input int n, input bit corrupt);
    int     span_lo [$];
    int     span_hi [$];
    int     lo;
    int     hi;
    int     r;
    int     k;
    int     pick;
    shape_e shape;
    entry_t e;
    plan_q.delete();
    pick = $urandom_range(0, 3);
    shape = (pick == 2) ? ShapeLeftChain : (pick == 3) ? ShapeRightChain : ShapeMixed;
    span_lo = {span_lo, 1};
    span_hi = {span_hi, n};
    while (span_lo.size() > 0) begin
      lo = span_lo.pop_back();
      hi = span_hi.pop_back();
      case (shape)
        ShapeLeftChain:  r = hi;
        ShapeRightChain: r = lo;
        default:         r = $urandom_range(lo, hi);
      endcase
      e = '{lo: lo, hi: hi, root: r, start_walk: 1'b0};
      plan_q = {plan_q, e};
      if (r > lo) begin
        span_lo = {span_lo, lo};
        span_hi = {span_hi, r - 1};
      end
      if (r < hi) begin
        span_lo = {span_lo, r + 1};
        span_hi = {span_hi, hi};
      end
    end
    for (k = plan_q.size() - 1; k > 0; k--) begin
      r = $urandom_range(0, k);
      e = plan_q[k];
      plan_q[k] = plan_q[r];
      plan_q[r] = e;
    end
    if (corrupt) begin
      k = $urandom_range(0, plan_q.size() - 1);
      e = plan_q[k];
      do r = $urandom_range(0, 31); while (r >= e.lo && r <= e.hi);
      e.root = r;
      plan_q[k] = e;
    end
    e = plan_q[plan_q.size() - 1];
    e.start_walk = 1'b1;
    plan_q[plan_q.size() - 1] = e;
  endtask

  // Stimulus and verdict.
  initial begin
    int          n;
    int          k;
    logic [31:0] raw;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.range_start <= '0;
    in_if.range_end   <= '0;
    in_if.root_key    <= '0;
    in_if.last_entry  <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    tx_calm  = 1'b0;
    table_ok = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest tree with the reset key count, then roots outside the one-key range.
    send_entry(1, 1, 1, 1'b1);
    send_entry(1, 1, 0, 1'b1);
    send_entry(1, 1, 31, 1'b1);
    // Unusable addresses: start zero, start too high, end before start, end zero.
    send_entry(0, 31, 7, 1'b0);
    send_entry(31, 16, 16, 1'b0);
    send_entry(16, 15, 3, 1'b0);
    send_entry(5, 0, 2, 1'b0);
    // Repair the table, then walk it from a dropped entry.
    send_entry(1, 1, 1, 1'b0);
    send_entry(17, 17, 1, 1'b1);
    // Register extremes: zero reads as one, all ones clamps to the largest tree.
    write_key_count(32'h0000_0000);
    write_key_count(32'hFFFF_FFFF);
    // Left chain over all keys: the deepest stack the walk can reach.
    for (k = 1; k <= MaxKeys; k++) send_entry(1, k, k, k == MaxKeys);

    // Random phases: a key count, then a few trees with noise around them.
    stored_items = 0;
    while (stored_items < RandomItems) begin
      case ($urandom_range(0, 7))
        0:       n = 1;
        1:       n = MaxKeys;
        2, 3:    n = $urandom_range(1, MaxKeys);
        default: n = $urandom_range(2, 5);
      endcase
      raw = 32'(n);
      if (n == 1 && $urandom_range(0, 1) == 0) raw = 32'd0;
      if (n == MaxKeys && $urandom_range(0, 1) == 0) raw = 32'($urandom_range(MaxKeys + 1, 31));
      if ($urandom_range(0, 3) == 0) raw = raw | ($urandom() & 32'hFFFF_FFE0);
      write_key_count(raw);
      table_ok = 1'b0;

      repeat ($urandom_range(1, 3)) begin
        // Stray writes to sound addresses may leave the table unusable for a bare walk.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            k = $urandom_range(1, MaxKeys);
            send_entry(k, $urandom_range(k, MaxKeys), $urandom_range(0, 31), 1'b0);
            stored_items++;
          end
          table_ok = 1'b0;
        end
        plan_tree(n, $urandom_range(0, 5) == 0);
        foreach (plan_q[idx]) begin
          if ($urandom_range(0, 4) == 0) send_dropped(1'b0);
          send_entry(plan_q[idx].lo, plan_q[idx].hi, plan_q[idx].root, plan_q[idx].start_walk);
          stored_items++;
        end
        table_ok = 1'b1;
        // Walk the stored table again from a dropped entry.
        if (table_ok && $urandom_range(0, 3) == 0) begin
          send_dropped(1'b1);
          stored_items++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
